FILE: rtl/bfi_pkg.sv
package bfi_pkg;

    localparam int BYTE_W    = 8;
    localparam int NB_W      = 17;
    localparam int NH_W      = 5;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 2;
    localparam int POS_W     = 16;
    localparam int BL_W      = 5;
    localparam int NEED_W    = NH_W + BL_W;
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = 1;
    localparam int Q_CNT_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_HASHES = 2'd1;

    localparam logic [NB_W-1:0] NUM_BITS_RST   = 17'd1024;
    localparam logic [NH_W-1:0] NUM_HASHES_RST = 5'd4;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_PRESENT  = 2'd1,
        ST_ABSENT   = 2'd2,
        ST_SHORT    = 2'd3
    } status_t;

    typedef struct packed {
        logic [NB_W-1:0] bits;
        logic [NH_W-1:0] hashes;
    } cfg_t;

    typedef struct packed {
        logic apply;
        logic finish;
        logic query;
        logic too_short;
        logic complete;
    } cmd_t;

    function automatic logic [BL_W-1:0] bit_len(input logic [NB_W-1:0] x);
        logic [BL_W-1:0] n;
        n = '0;
        for (int i = 0; i < NB_W; i++)
        begin
            if (x[i])
            begin
                n = BL_W'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

FILE: rtl/bloom_filter_byte_sum_index.sv
// Bloom filter fed one byte per transfer. The first byte of a value waits in
// the front end for a 9-bit serial length divider that sets the block length;
// every further byte goes straight to the push step of the front end. Each
// completed block passes through the back end as a 17-bit serial modulo, then
// one access of the single bit-wide array; a two-entry queue lets the front run
// ahead, so values with long blocks stream at the front end's pace and values
// with one-byte blocks run at the back end's pace. After reset a clearing pass
// writes all MAX_BITS entries of the bit array (65536 by default) with in_ready
// low; configuration writes are taken at any time and are to be made only with
// the block drained.
module bloom_filter_byte_sum_index
    import bfi_pkg::*;
#(
    parameter int MAX_BITS        = 65536,
    parameter int MAX_HASHES      = 16,
    parameter int MAX_VALUE_BYTES = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_W-1:0]              cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          mode,
    input  logic [BYTE_W-1:0]             value_byte,
    input  logic [$clog2(MAX_VALUE_BYTES+1)-1:0] value_length,
    input  logic                          last_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    status
);

    localparam int LEN_W = $clog2(MAX_VALUE_BYTES + 1);
    localparam int SUM_W = BYTE_W + LEN_W;
    localparam int Q_W   = $bits(cmd_t) + SUM_W + NB_W;
    localparam logic [31:0] MAX_BITS_C   = 32'(MAX_BITS);
    localparam logic [31:0] MAX_HASHES_C = 32'(MAX_HASHES);

    logic [NB_W-1:0]  num_bits_reg;
    logic [NH_W-1:0]  num_hashes_reg;
    cfg_t             cfg;
    logic             clearing;

    logic             f_valid;
    logic             f_ready;
    cmd_t             f_cmd;
    logic [SUM_W-1:0] f_sum;
    logic [NB_W-1:0]  f_bits;
    logic             b_valid;
    logic             b_ready;
    cmd_t             b_cmd;
    logic [SUM_W-1:0] b_sum;
    logic [NB_W-1:0]  b_bits;
    logic [Q_W-1:0]   b_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_bits_reg   <= NUM_BITS_RST;
            num_hashes_reg <= NUM_HASHES_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_NUM_BITS:   num_bits_reg   <= cfg_data[NB_W-1:0];
                REG_NUM_HASHES: num_hashes_reg <= cfg_data[NH_W-1:0];
                default:        ;
            endcase
        end
    end

    // zero acts as one, oversize clamps to the maximum
    always_comb
    begin
        priority if (num_bits_reg == '0)
        begin
            cfg.bits = NB_W'(1);
        end
        else if (32'(num_bits_reg) > MAX_BITS_C)
        begin
            cfg.bits = NB_W'(MAX_BITS_C);
        end
        else
        begin
            cfg.bits = num_bits_reg;
        end

        priority if (num_hashes_reg == '0)
        begin
            cfg.hashes = NH_W'(1);
        end
        else if (32'(num_hashes_reg) > MAX_HASHES_C)
        begin
            cfg.hashes = NH_W'(MAX_HASHES_C);
        end
        else
        begin
            cfg.hashes = num_hashes_reg;
        end
    end

    bfi_front #(
        .LEN_W (LEN_W),
        .SUM_W (SUM_W)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .clearing     (clearing),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .value_byte   (value_byte),
        .value_length (value_length),
        .last_byte    (last_byte),
        .q_valid      (f_valid),
        .q_ready      (f_ready),
        .q_cmd        (f_cmd),
        .q_sum        (f_sum),
        .q_bits       (f_bits)
    );

    bfi_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  ({f_cmd, f_sum, f_bits}),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (b_data)
    );

    assign {b_cmd, b_sum, b_bits} = b_data;

    bfi_back #(
        .SUM_W (SUM_W),
        .DEPTH (MAX_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (b_valid),
        .q_ready   (b_ready),
        .q_cmd     (b_cmd),
        .q_sum     (b_sum),
        .q_bits    (b_bits),
        .clearing  (clearing),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status)
    );

endmodule

FILE: rtl/bfi_ram.sv
module bfi_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/bfi_div.sv
module bfi_div #(
    parameter int DVD_W = 9,
    parameter int DVS_W = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient,
    output logic [DVS_W-1:0] remainder
);

    localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] dvs_reg;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             ge;
    logic [DVS_W-1:0] rem_next;

    // restoring division, one quotient bit a cycle
    always_comb
    begin
        trial    = {rem_reg, quo_reg[DVD_W-1]};
        ge       = trial >= {1'b0, dvs_reg};
        diff     = trial - {1'b0, dvs_reg};
        rem_next = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DVD_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

FILE: rtl/bfi_queue.sv
module bfi_queue
    import bfi_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0]   slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] cnt_reg;
    logic               do_push;
    logic               do_pop;

    assign push_ready = cnt_reg != Q_CNT_W'(Q_DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + Q_CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - Q_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/bfi_front.sv
module bfi_front
    import bfi_pkg::*;
#(
    parameter int LEN_W = 9,
    parameter int SUM_W = 17
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              clearing,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              mode,
    input  logic [BYTE_W-1:0] value_byte,
    input  logic [LEN_W-1:0]  value_length,
    input  logic              last_byte,
    output logic              q_valid,
    input  logic              q_ready,
    output cmd_t              q_cmd,
    output logic [SUM_W-1:0]  q_sum,
    output logic [NB_W-1:0]   q_bits
);

    localparam int BND_W = LEN_W + NH_W;
    localparam int CMP_W = (POS_W + 1 > BND_W) ? POS_W + 1 : BND_W;

    typedef enum logic [2:0] {
        F_TAKE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } fstate_t;

    fstate_t           state_reg;
    logic              first_reg;
    logic              query_reg;
    logic              short_reg;
    logic              last_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [NH_W-1:0]   bn_reg;
    logic [BND_W-1:0]  bnd_reg;
    logic [LEN_W-1:0]  blen_reg;
    logic [BYTE_W-1:0] byte_reg;

    logic              take;
    logic [NEED_W-1:0] need;
    logic              too_short;
    logic              div_done;
    logic [LEN_W-1:0]  div_quo;
    logic [NH_W-1:0]   div_rem;
    logic              acc;
    logic              hit;
    logic              zero_fill;
    logic              need_push;
    logic              advance;
    logic [SUM_W-1:0]  sum_acc;
    logic [POS_W:0]    pos_p1;
    logic [NH_W:0]     bn_inc;
    logic [NH_W:0]     bn_after;

    assign in_ready = (state_reg == F_TAKE) && !clearing;
    assign take     = in_valid && in_ready;

    // minimum length: hashes * bitlen(bits) / 8
    always_comb
    begin
        need      = (NEED_W'(cfg.hashes) * NEED_W'(bit_len(cfg.bits))) >> 3;
        too_short = value_length < need;
    end

    bfi_div #(
        .DVD_W (LEN_W),
        .DVS_W (NH_W)
    ) u_len_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (take && first_reg),
        .dividend  (value_length),
        .divisor   (cfg.hashes),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb
    begin
        acc       = !short_reg && (blen_reg != '0) && (bn_reg < cfg.hashes);
        sum_acc   = sum_reg + SUM_W'(byte_reg);
        pos_p1    = {1'b0, pos_reg} + (POS_W + 1)'(1);
        hit       = acc && (CMP_W'(pos_p1) == CMP_W'(bnd_reg));
        zero_fill = last_reg && !short_reg && (blen_reg == '0);
        bn_inc    = {1'b0, bn_reg} + (NH_W + 1)'(1);
        bn_after  = hit ? bn_inc : {1'b0, bn_reg};

        q_cmd.apply     = hit || zero_fill;
        q_cmd.finish    = last_reg;
        q_cmd.query     = query_reg;
        q_cmd.too_short = short_reg;
        q_cmd.complete  = zero_fill || (bn_after >= {1'b0, cfg.hashes});
        q_sum           = hit ? sum_acc : '0;
        q_bits          = cfg.bits;

        need_push = hit || zero_fill || last_reg;
        q_valid   = (state_reg == F_PUSH) && need_push;
        advance   = (state_reg == F_PUSH) && (!need_push || q_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_TAKE;
            first_reg <= 1'b1;
            query_reg <= 1'b0;
            short_reg <= 1'b0;
            last_reg  <= 1'b0;
            pos_reg   <= '0;
            sum_reg   <= '0;
            bn_reg    <= '0;
            bnd_reg   <= '0;
            blen_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                F_TAKE:
                begin
                    if (take)
                    begin
                        last_reg <= last_byte;
                        if (first_reg)
                        begin
                            first_reg <= 1'b0;
                            query_reg <= mode;
                            short_reg <= too_short;
                            pos_reg   <= '0;
                            sum_reg   <= '0;
                            bn_reg    <= '0;
                            state_reg <= F_DIV;
                        end
                        else
                        begin
                            state_reg <= F_PUSH;
                        end
                    end
                end
                F_DIV:
                begin
                    if (div_done)
                    begin
                        blen_reg  <= short_reg ? '0 : div_quo;
                        bnd_reg   <= short_reg ? '0 : BND_W'(div_quo);
                        state_reg <= F_PUSH;
                    end
                end
                F_PUSH:
                begin
                    if (advance)
                    begin
                        if (pos_reg != '1)
                        begin
                            pos_reg <= pos_p1[POS_W-1:0];
                        end
                        sum_reg <= hit ? '0 : (acc ? sum_acc : sum_reg);
                        if (hit)
                        begin
                            bn_reg  <= bn_inc[NH_W-1:0];
                            bnd_reg <= bnd_reg + BND_W'(blen_reg);
                        end
                        if (last_reg)
                        begin
                            first_reg <= 1'b1;
                        end
                        state_reg <= F_TAKE;
                    end
                end
                default:
                begin
                    state_reg <= F_TAKE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= value_byte;
        end
    end

endmodule

FILE: rtl/bfi_back.sv
module bfi_back
    import bfi_pkg::*;
#(
    parameter int SUM_W = 17,
    parameter int DEPTH = 65536
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    output logic             q_ready,
    input  cmd_t             q_cmd,
    input  logic [SUM_W-1:0] q_sum,
    input  logic [NB_W-1:0]  q_bits,
    output logic             clearing,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [1:0]       status
);

    localparam int IDX_W = $clog2(DEPTH);

    typedef enum logic [4:0] {
        B_CLEAR = 5'b00001,
        B_IDLE  = 5'b00010,
        B_MOD   = 5'b00100,
        B_CHECK = 5'b01000,
        B_DONE  = 5'b10000
    } bstate_t;

    bstate_t          state_reg;
    bstate_t          state_next;
    cmd_t             cmd_reg;
    logic [IDX_W-1:0] clr_addr_reg;
    logic             all_set_reg;
    logic             out_valid_reg;
    status_t          status_reg;

    logic             mod_done;
    logic [SUM_W-1:0] mod_quo;
    logic [NB_W-1:0]  mod_rem;
    logic [IDX_W-1:0] idx;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic             ram_wdata;
    logic             ram_rdata;
    logic             out_free;
    status_t          status_new;

    assign q_ready  = state_reg == B_IDLE;
    assign clearing = state_reg == B_CLEAR;
    assign out_free = !out_valid_reg || out_ready;
    assign idx      = IDX_W'(mod_rem);

    bfi_div #(
        .DVD_W (SUM_W),
        .DVS_W (NB_W)
    ) u_mod_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     ((state_reg == B_IDLE) && q_valid && q_cmd.apply),
        .dividend  (q_sum),
        .divisor   (q_bits),
        .done      (mod_done),
        .quotient  (mod_quo),
        .remainder (mod_rem)
    );

    always_comb
    begin
        ram_we    = clearing || ((state_reg == B_MOD) && mod_done && !cmd_reg.query);
        ram_waddr = clearing ? clr_addr_reg : idx;
        ram_wdata = !clearing;
    end

    bfi_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_bit_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        priority if (cmd_reg.too_short)
        begin
            status_new = ST_SHORT;
        end
        else if (!cmd_reg.query)
        begin
            status_new = ST_INSERTED;
        end
        else if (all_set_reg && cmd_reg.complete)
        begin
            status_new = ST_PRESENT;
        end
        else
        begin
            status_new = ST_ABSENT;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_CLEAR:
            begin
                if (clr_addr_reg == IDX_W'(DEPTH - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = q_cmd.apply ? B_MOD : B_DONE;
                end
            end
            B_MOD:
            begin
                if (mod_done)
                begin
                    if (cmd_reg.query)
                    begin
                        state_next = B_CHECK;
                    end
                    else
                    begin
                        state_next = cmd_reg.finish ? B_DONE : B_IDLE;
                    end
                end
            end
            B_CHECK:
            begin
                state_next = cmd_reg.finish ? B_DONE : B_IDLE;
            end
            B_DONE:
            begin
                if (out_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_addr_reg  <= '0;
            all_set_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
            cmd_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
            begin
                clr_addr_reg <= clr_addr_reg + IDX_W'(1);
            end
            if ((state_reg == B_IDLE) && q_valid)
            begin
                cmd_reg <= q_cmd;
            end
            if ((state_reg == B_CHECK) && !ram_rdata)
            begin
                all_set_reg <= 1'b0;
            end
            else if ((state_reg == B_DONE) && out_free)
            begin
                all_set_reg <= 1'b1;
            end
            if ((state_reg == B_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == B_DONE) && out_free)
        begin
            status_reg <= status_new;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;

endmodule

FILE: rtl/bfi_checker.sv
module bfi_props (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       last_byte,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] status
);

    logic [3:0] pending_reg;
    logic       last_xfer;
    logic       out_xfer;

    assign last_xfer = in_valid && in_ready && last_byte;
    assign out_xfer  = out_valid && out_ready;

    // values whose result has not been transferred yet
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (last_xfer && !out_xfer)
        begin
            pending_reg <= pending_reg + 4'd1;
        end
        else if (out_xfer && !last_xfer)
        begin
            pending_reg <= pending_reg - 4'd1;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status))
        else $error("result dropped or changed while stalled");

    a_in_gap: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("byte taken in back-to-back cycles");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 4'd0)
        else $error("result without a finished value");

endmodule

bind bloom_filter_byte_sum_index bfi_props u_bfi_props (.*);

FILE: dv/bfi_checker.sv
module bfi_checker
    import bfi_pkg::*;
#(
    parameter int MAX_BITS   = 65536,
    parameter int MAX_HASHES = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic                 mode,
    input  logic [BYTE_W-1:0]    value_byte,
    input  logic [8:0]           value_length,
    input  logic                 last_byte,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [1:0]           status,
    output int                   pending,
    output int                   errors
);
    timeunit 1ns;
    timeprecision 1ps;

    bit              filt [MAX_BITS];
    logic [NB_W-1:0] nb_reg;
    logic [NH_W-1:0] nh_reg;

    int unsigned byte_pos;
    int unsigned block_acc;
    int unsigned blocks_done;
    int unsigned block_len;
    bit          hits_so_far;
    bit          is_query;
    bit          is_short;

    status_t     status_due [$];
    int          err_count;

    function automatic int unsigned filter_size();
        if (nb_reg == '0)
            return 1;
        if (nb_reg > MAX_BITS)
            return MAX_BITS;
        return nb_reg;
    endfunction

    function automatic int unsigned hash_count();
        if (nh_reg == '0)
            return 1;
        if (nh_reg > MAX_HASHES)
            return MAX_HASHES;
        return nh_reg;
    endfunction

    task automatic clear_value();
        byte_pos    = 0;
        block_acc   = 0;
        blocks_done = 0;
        block_len   = 0;
        hits_so_far = 1'b1;
        is_query    = 1'b0;
        is_short    = 1'b0;
    endtask

    task automatic close_block(input int unsigned sum);
        int unsigned slot;
        slot = sum % filter_size();
        if (is_query)
        begin
            if (!filt[slot])
                hits_so_far = 1'b0;
        end
        else
        begin
            filt[slot] = 1'b1;
        end
        blocks_done++;
        block_acc = 0;
    endtask

    task automatic absorb_byte(input bit m, input logic [7:0] b, input logic [8:0] vlen,
                               input bit lst);
        int unsigned k;
        int unsigned need;
        status_t     st;
        k = hash_count();
        if (byte_pos == 0)
        begin
            need        = (k * $clog2(filter_size() + 1)) / 8;
            is_query    = m;
            is_short    = vlen < need;
            block_len   = is_short ? 0 : vlen / k;
            blocks_done = 0;
            block_acc   = 0;
            hits_so_far = 1'b1;
        end
        if (!is_short && block_len != 0 && blocks_done < k)
        begin
            block_acc += b;
            if (byte_pos + 1 == (blocks_done + 1) * block_len)
                close_block(block_acc);
        end
        if (byte_pos < 16'hFFFF)
            byte_pos++;
        if (lst)
        begin
            if (is_short)
            begin
                st = ST_SHORT;
            end
            else
            begin
                if (block_len == 0)
                begin
                    while (blocks_done < k)
                        close_block(0);
                end
                if (!is_query)
                    st = ST_INSERTED;
                else if (hits_so_far && blocks_done >= k)
                    st = ST_PRESENT;
                else
                    st = ST_ABSENT;
            end
            status_due.push_back(st);
            clear_value();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (filt[i])
                filt[i] = 1'b0;
            nb_reg    = NUM_BITS_RST;
            nh_reg    = NUM_HASHES_RST;
            clear_value();
            status_due.delete();
            err_count = 0;
            pending   <= 0;
            errors    <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_NUM_BITS:   nb_reg = cfg_data[NB_W-1:0];
                    REG_NUM_HASHES: nh_reg = cfg_data[NH_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                absorb_byte(mode, value_byte, value_length, last_byte);
            if (out_valid && out_ready)
            begin
                if (status_due.size() == 0)
                begin
                    $error("status: unexpected transfer, expected none, got %0d", status);
                    err_count++;
                end
                else if (status !== status_due[0])
                begin
                    $error("status: expected %0d, got %0d", status_due[0], status);
                    err_count++;
                    void'(status_due.pop_front());
                end
                else
                begin
                    void'(status_due.pop_front());
                end
            end
            pending <= status_due.size();
            errors  <= err_count;
        end
    end

endmodule

FILE: dv/tb_bloom_filter_byte_sum_index.sv
module tb_bloom_filter_byte_sum_index
    import bfi_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_PHASES     = 10;
    localparam int PHASE_BYTES  = 160;
    localparam int SETTLE       = 100;
    localparam int FILL_TAG     = -1;
    localparam int FILL_RANDOM  = -2;
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [CFG_W-1:0]     cfg_data     = '0;
    logic                 in_valid     = 1'b0;
    logic                 in_ready;
    logic                 mode         = MODE_INSERT;
    logic [BYTE_W-1:0]    value_byte   = '0;
    logic [8:0]           value_length = '0;
    logic                 last_byte    = 1'b0;
    logic                 out_valid;
    logic                 out_ready    = 1'b0;
    logic [1:0]           status;
    int                   pending;
    int                   errors;

    bit                   no_gaps = 1'b0;
    int                   bytes_sent = 0;
    int                   ready_hold = 0;
    int                   ready_roll;

    logic [CFG_W-1:0] phase_bits [N_PHASES] = '{
        17'd65536, 17'd1, 17'd0, 17'h1FFFF, 17'd100,
        17'd7, 17'd2, 17'd1024, 17'd300, 17'd5000
    };
    logic [NH_W-1:0] phase_hashes [N_PHASES] = '{
        5'd16, 5'd1, 5'd0, 5'd31, 5'd3, 5'd5, 5'd16, 5'd4, 5'd2, 5'd8
    };

    bloom_filter_byte_sum_index dut (.*);

    bfi_checker chk (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold <= ready_hold - 1;
        end
        else
        begin
            ready_roll = $urandom_range(0, 99);
            if (ready_roll < 60)
            begin
                out_ready  <= 1'b1;
                ready_hold <= $urandom_range(0, 20);
            end
            else if (ready_roll < 95)
            begin
                out_ready  <= 1'b0;
                ready_hold <= $urandom_range(0, 3);
            end
            else
            begin
                out_ready  <= 1'b0;
                ready_hold <= $urandom_range(15, 60);
            end
        end
    end

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] tag_byte(input int tag, input int i);
        return 8'(tag * 73 + i * 151 + i * i * 13 + (tag << 4) * i);
    endfunction

    function automatic int tag_len(input int tag);
        return 1 + (tag * 11 + 3) % 40;
    endfunction

    task automatic send_byte(input logic m, input logic [7:0] b, input logic [8:0] len,
                             input logic lst);
        int gap;
        mode         <= m;
        value_byte   <= b;
        value_length <= len;
        last_byte    <= lst;
        in_valid     <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
        gap = idle_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_value(input logic m, input int len, input int nbytes, input int tag,
                              input int fill, input bit scramble);
        logic [7:0] b;
        logic [8:0] l;
        for (int i = 0; i < nbytes; i++)
        begin
            if (fill == FILL_TAG)
                b = tag_byte(tag, i);
            else if (fill == FILL_RANDOM)
                b = 8'($urandom);
            else
                b = 8'(fill);
            l = (scramble && i > 0) ? 9'($urandom) : 9'(len);
            send_byte(m, b, l, i == nbytes - 1);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // pending is registered and lags the transfers
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic random_value();
        int   kind;
        int   r;
        int   len;
        int   nbytes;
        int   tag;
        int   fill;
        bit   scramble;
        logic m;
        kind     = $urandom_range(0, 99);
        m        = $urandom_range(0, 1) ? MODE_QUERY : MODE_INSERT;
        no_gaps  = ($urandom_range(0, 4) == 0);
        scramble = 1'b0;
        tag      = $urandom_range(0, 15);
        if (kind < 60)
        begin
            len  = tag_len(tag);
            fill = FILL_TAG;
        end
        else
        begin
            fill = FILL_RANDOM;
            r    = $urandom_range(0, 99);
            if (r < 85)
                len = $urandom_range(1, 40);
            else if (r < 97)
                len = $urandom_range(41, 120);
            else
                len = $urandom_range(121, 256);
        end
        nbytes = len;
        r = $urandom_range(0, 99);
        if (r < 8)
            nbytes = $urandom_range(1, len);
        else if (r < 16)
            nbytes = len + $urandom_range(1, 6);
        else if (r < 22)
            scramble = 1'b1;
        send_value(m, len, nbytes, tag, fill, scramble);
        if ($urandom_range(0, 99) < 2)
            wait_drained();
    endtask

    initial
    begin
        logic [CFG_W-1:0] hash_word;
        int               start;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset setting: 1024 bits, 4 hashes, so five bytes at least
        send_value(MODE_INSERT, 4, 1, 0, 0, 1'b0);
        send_value(MODE_INSERT, 5, 5, 0, 255, 1'b0);
        send_value(MODE_QUERY, 5, 5, 0, 255, 1'b0);
        send_value(MODE_QUERY, 6, 2, 0, 0, 1'b0);
        send_value(MODE_INSERT, 256, 1, 0, 128, 1'b0);
        send_value(MODE_QUERY, 5, 7, 3, FILL_TAG, 1'b0);
        wait_drained();

        // one-bit filter with sixteen hashes: blocks of zero length
        write_reg(REG_NUM_BITS, 17'd1);
        write_reg(REG_NUM_HASHES, 17'd16);
        send_value(MODE_INSERT, 3, 3, 0, FILL_RANDOM, 1'b0);
        send_value(MODE_QUERY, 2, 2, 0, FILL_RANDOM, 1'b0);

        for (int p = 0; p < N_PHASES; p++)
        begin
            wait_drained();
            write_reg(REG_NUM_BITS, phase_bits[p]);
            hash_word = CFG_W'($urandom);
            hash_word[NH_W-1:0] = phase_hashes[p];
            write_reg(REG_NUM_HASHES, hash_word);
            if (p == 3)
                write_reg(REG_SPARE, CFG_W'($urandom));
            start = bytes_sent;
            while (bytes_sent - start < PHASE_BYTES)
                random_value();
        end

        wait_drained();
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #15ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
